@@ src/mm_pkg.sv @@
// Shared types and constants for the modular multiplier.
package mm_pkg;

   // Width of the operand and result fields on the stream ports.
   localparam int FIELD_WIDTH = 64;

   // Configuration port geometry: one 64-bit register, 8-byte slots.
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_ADDR_WIDTH = 4;

   // Register slot selected by the slot bit of the address.
   localparam logic REG_MODULUS = 1'b0;

   // Factors of the default modulus, (13*17)^2.
   localparam logic [63:0] P_FACTOR = 64'd13;
   localparam logic [63:0] Q_FACTOR = 64'd17;
   localparam logic [63:0] MODULUS_RESET = (P_FACTOR * Q_FACTOR) * (P_FACTOR * Q_FACTOR);

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_MULT   = 5'b01000,
      ST_FLUSH  = 5'b10000
   } mm_state_type;

   // Strobes from the sequencer to the datapath units.
   typedef struct packed {
      logic accept;      // a request is taken this cycle
      logic red_step;    // one remainder bit step
      logic acc_load;    // load the reduced multiplicand, clear the sum
      logic acc_step;    // one add-and-double step
   } mm_ctrl_type;

endpackage

@@ src/modular_multiplier_unit.sv @@
// Modular multiplier top level: stream ports, register port and sequencer.
//
// Usage:
//   A request on req_ carries the multiplicand and multiplier; one result on rsp_
//   carries their product modulo the modulus register. The modulus is written
//   through the csr_ port (64-bit register at byte address 0) while the block is idle.
//   Operands and modulus are taken in their low OPERAND_WIDTH bits.
//   One request is worked on at a time. After acceptance the sequencer steps the
//   bit-serial remainder unit once per multiplicand bit, loads the add-and-double
//   unit, steps it once per multiplier bit, and then hands the result to the output
//   register. A zero modulus skips both units and goes straight to the hand-over,
//   giving a zero product. The next request is taken only once the sequencer is
//   back in idle after the hand-over.
//   req_tready is high whenever no request is in work, also while a finished
//   result still sits in the output register. If the receiver stalls and the
//   output register is full, the next result waits in the datapath until the
//   register frees; the block takes no new request meanwhile.
//   Reset clears the sequencer and the output valid and sets the modulus to
//   48841, the square of 13 times 17.
module modular_multiplier_unit
   import mm_pkg::*;
#(
   parameter int OPERAND_WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [2*FIELD_WIDTH-1:0]  req_tdata,   // multiplicand [63:0], multiplier [127:64]
   // Result channel.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [FIELD_WIDTH-1:0]    rsp_tdata,   // product [63:0]
   // Register port.
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int CNT_WIDTH = $clog2(OPERAND_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(OPERAND_WIDTH - 1);

   mm_state_type                state_ff, state_in;
   logic [CNT_WIDTH-1:0]        count_ff, count_in;
   logic                        zero_ff, zero_in;
   logic [CSR_DATA_WIDTH-1:0]   modulus_ff, modulus_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic [FIELD_WIDTH-1:0]      rsp_tdata_ff, rsp_tdata_in;
   mm_ctrl_type                 ctrl;
   logic [OPERAND_WIDTH-1:0]    modulus;
   logic [OPERAND_WIDTH-1:0]    remainder;
   logic [OPERAND_WIDTH-1:0]    sum;
   logic                        req_accept;
   logic                        out_free;
   logic                        csr_write;

   assign modulus    = modulus_ff[OPERAND_WIDTH-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Register port: writes complete in the access phase, reads are combinational.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[3] == REG_MODULUS) ? modulus_ff : '0;

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_write && (csr_paddr[3] == REG_MODULUS)) begin
         modulus_in = csr_pwdata;
      end
   end

   // Sequencer: reduce, load, scan the multiplier, hand over (zero modulus: hand over only).
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      zero_in       = zero_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      ctrl          = '0;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ctrl.accept = 1'b1;
               count_in    = '0;
               zero_in     = (modulus == '0);
               state_in    = (modulus == '0) ? ST_FLUSH : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            ctrl.red_step = 1'b1;
            count_in      = count_ff + 1'b1;
            if (count_ff == CNT_LAST) begin
               count_in = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctrl.acc_load = 1'b1;
            state_in      = ST_MULT;
         end
         ST_MULT: begin
            ctrl.acc_step = 1'b1;
            count_in      = count_ff + 1'b1;
            if (count_ff == CNT_LAST) begin
               count_in = '0;
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = zero_ff ? '0 : FIELD_WIDTH'(sum);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         zero_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         modulus_ff    <= MODULUS_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         zero_ff       <= zero_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         modulus_ff    <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Bit-serial remainder of the multiplicand.
   mm_reducer #(
      .WIDTH(OPERAND_WIDTH)
   ) u_reducer (
      .clock     (clock),
      .ctrl      (ctrl),
      .dividend  (req_tdata[OPERAND_WIDTH-1:0]),
      .modulus   (modulus),
      .remainder (remainder)
   );

   // Interleaved add-and-double over the multiplier bits.
   mm_accumulator #(
      .WIDTH(OPERAND_WIDTH)
   ) u_accumulator (
      .clock      (clock),
      .ctrl       (ctrl),
      .multiplier (req_tdata[FIELD_WIDTH +: OPERAND_WIDTH]),
      .reduced    (remainder),
      .modulus    (modulus),
      .sum        (sum)
   );

`ifndef SYNTH
   // A new result appears only out of the hand-over state.
   a_rsp_from_flush: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_FLUSH))
      else $error("result raised outside hand-over");

   // An accepted request always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // The reduced multiplicand is a residue when it is loaded.
   a_rem_residue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (remainder < modulus))
      else $error("remainder not below modulus");

   // The running sum stays a residue throughout the scan.
   a_sum_residue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULT) |-> (sum < modulus))
      else $error("running sum not below modulus");
`endif

endmodule

@@ src/mm_reducer.sv @@
// Bit-serial restoring remainder unit: reduces the multiplicand modulo the modulus.
module mm_reducer
   import mm_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  mm_ctrl_type      ctrl,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] modulus,
   output logic [WIDTH-1:0] remainder
);

   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH:0]   trial;

   // Shift the next dividend bit into the partial remainder and subtract if it fits.
   always_comb begin
      trial  = {rem_ff, dvd_ff[WIDTH-1]};
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      if (ctrl.accept) begin
         dvd_in = dividend;
         rem_in = '0;
      end else if (ctrl.red_step) begin
         dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, modulus}) begin
            rem_in = WIDTH'(trial - {1'b0, modulus});
         end else begin
            rem_in = trial[WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;

endmodule

@@ src/mm_accumulator.sv @@
// Interleaved add-and-double unit: scans the multiplier one bit per cycle.
module mm_accumulator
   import mm_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  mm_ctrl_type      ctrl,
   input  logic [WIDTH-1:0] multiplier,
   input  logic [WIDTH-1:0] reduced,
   input  logic [WIDTH-1:0] modulus,
   output logic [WIDTH-1:0] sum
);

   logic [WIDTH-1:0] mplier_ff, mplier_in;
   logic [WIDTH-1:0] mcand_ff, mcand_in;
   logic [WIDTH-1:0] acc_ff, acc_in;

   // Modular add of two residues, with one extra bit for the carry.
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                input logic [WIDTH-1:0] y,
                                                input logic [WIDTH-1:0] m);
      logic [WIDTH:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[WIDTH-1:0];
   endfunction

   // The multiplier shifts right; its low bit gates the add, the multiplicand doubles.
   always_comb begin
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      if (ctrl.accept) begin
         mplier_in = multiplier;
      end
      if (ctrl.acc_load) begin
         mcand_in = reduced;
         acc_in   = '0;
      end else if (ctrl.acc_step) begin
         mplier_in = {1'b0, mplier_ff[WIDTH-1:1]};
         mcand_in  = add_mod(mcand_ff, mcand_ff, modulus);
         if (mplier_ff[0]) begin
            acc_in = add_mod(acc_ff, mcand_ff, modulus);
         end
      end
   end

   always_ff @(posedge clock) begin
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
   end

   assign sum = acc_ff;

endmodule

@@ bench/modular_multiplier_checker.sv @@
// Checker that predicts and compares every product leaving the modular multiplier.
module modular_multiplier_checker
   import mm_pkg::*;
#(
   parameter int OPERAND_WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [2*FIELD_WIDTH-1:0]  req_tdata,   // multiplicand [63:0], multiplier [127:64]
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [FIELD_WIDTH-1:0]    rsp_tdata,   // product [63:0]
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic                      csr_pready,
   output int                        outstanding,
   output int                        failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] OPERAND_MASK =
      (OPERAND_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << OPERAND_WIDTH) - 64'd1);

   typedef struct packed {
      logic [63:0] multiplicand;
      logic [63:0] multiplier;
      logic [63:0] modulus;
      logic [63:0] product;
   } product_entry_type;

   product_entry_type pending_products[$];
   product_entry_type oldest;
   product_entry_type incoming;
   logic [63:0]       modulus_copy = MODULUS_RESET;
   int                mismatch_count = 0;

   // Sum of two residues below m, kept exact with a carry bit.
   function automatic logic [63:0] residue_sum(input logic [63:0] x, input logic [63:0] y,
                                               input logic [63:0] m);
      logic [64:0] sum;
      sum = {1'b0, x} + {1'b0, y};
      if (sum >= {1'b0, m}) begin
         sum = sum - {1'b0, m};
      end
      return sum[63:0];
   endfunction

   // Interleaved product: add the doubling multiplicand on each set multiplier bit.
   function automatic logic [63:0] modular_product(input logic [63:0] a, input logic [63:0] b,
                                                   input logic [63:0] m);
      logic [63:0] modv;
      logic [63:0] addend;
      logic [63:0] bits;
      logic [63:0] acc;
      modv = m & OPERAND_MASK;
      bits = b & OPERAND_MASK;
      acc = 64'd0;
      // A zero modulus has no residues; the block answers zero.
      if (modv == 64'd0) begin
         return 64'd0;
      end
      addend = (a & OPERAND_MASK) % modv;
      for (int i = 0; i < OPERAND_WIDTH; i++) begin
         if (bits[i]) begin
            acc = residue_sum(acc, addend, modv);
         end
         addend = residue_sum(addend, addend, modv);
      end
      return acc;
   endfunction

   // Watch all three ports at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         pending_products.delete();
         modulus_copy = MODULUS_RESET;
      end else begin
         // Results are matched before new requests are queued.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_products.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected product: expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               oldest = pending_products.pop_front();
               if (rsp_tdata !== oldest.product) begin
                  mismatch_count++;
                  $display("%0t: product mismatch for %h * %h mod %h: expected %h, actual %h",
                           $time, oldest.multiplicand, oldest.multiplier, oldest.modulus,
                           oldest.product, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            incoming.multiplicand = req_tdata[63:0];
            incoming.multiplier = req_tdata[127:64];
            incoming.modulus = modulus_copy;
            incoming.product = modular_product(incoming.multiplicand, incoming.multiplier,
                                               modulus_copy);
            pending_products.push_back(incoming);
         end
         // Track modulus writes; the user must make them only while the block is idle.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_WIDTH-1] == REG_MODULUS) begin
            modulus_copy = csr_pwdata[63:0];
         end
      end
      outstanding <= pending_products.size();
      failures <= mismatch_count;
   end

endmodule

@@ bench/modular_multiplier_unit_test.sv @@
// Top-level testbench: drives requests and modulus writes, then reports the verdict.
module modular_multiplier_unit_test
   import mm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OPERAND_WIDTH = 64;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int LONG_STALL = 1000;
   localparam int BATCH_ITEMS = 100;
   localparam int BATCHES_PER_PHASE = 6;
   localparam logic [CSR_ADDR_WIDTH-1:0] MODULUS_ADDR = {REG_MODULUS, 3'b000};
   localparam logic [63:0] ALL_ONES = {64{1'b1}};
   localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [2*FIELD_WIDTH-1:0]  req_tdata = '0;   // multiplicand [63:0], multiplier [127:64]
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [FIELD_WIDTH-1:0]    rsp_tdata;       // product [63:0]
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int outstanding;
   int failures;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int stall_requests = 0;
   int stalls_served = 0;
   int hold_left = 0;
   int cycle_count = 0;
   logic [63:0] current_modulus = MODULUS_RESET;

   modular_multiplier_unit #(.OPERAND_WIDTH(OPERAND_WIDTH)) uut (.*);

   modular_multiplier_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_checker (.*);

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side: random back-pressure, plus a long hold-off when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (stalls_served != stall_requests) begin
            stalls_served++;
            hold_left = LONG_STALL;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Operand biased toward the edges of the current modulus.
   function automatic logic [63:0] pick_operand(input logic [63:0] m);
      case ($urandom_range(0, 9))
         0: return 64'd0;
         1: return ALL_ONES;
         2: return m - 64'd1;
         3: return m;
         4: return m + 64'd1;
         5: return 64'($urandom_range(0, 255));
         default: return random_word();
      endcase
   endfunction

   // Offer one request, with random idle cycles before it, and wait for its acceptance.
   task automatic offer_request(input logic [63:0] multiplicand, input logic [63:0] multiplier);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {multiplier, multiplicand};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every expected product has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Write the modulus register once the block is idle.
   task automatic change_modulus(input logic [63:0] value);
      wait_idle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MODULUS_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      current_modulus = value;
   endtask

   // Main sequence.
   initial begin
      logic [63:0] next_modulus;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed checks under the reset modulus.
      offer_request(64'd0, 64'd0);
      offer_request(ALL_ONES, ALL_ONES);
      offer_request(MODULUS_RESET - 64'd1, MODULUS_RESET - 64'd1);
      offer_request(MODULUS_RESET, 64'd123456789);
      offer_request(64'd1, ALL_ONES);
      offer_request(ALL_ONES, 64'd1);
      offer_request(TOP_BIT, 64'd2);
      offer_request(random_word(), 64'd0);

      // Largest modulus: sums overflow 64 bits.
      change_modulus(ALL_ONES);
      offer_request(ALL_ONES - 64'd1, ALL_ONES - 64'd1);
      offer_request(ALL_ONES, 64'd2);
      offer_request(TOP_BIT, TOP_BIT);
      offer_request(TOP_BIT + 64'd1, ALL_ONES);

      // Modulus just above half the range.
      change_modulus(TOP_BIT + 64'd1);
      offer_request(TOP_BIT, TOP_BIT);
      offer_request(ALL_ONES, ALL_ONES);
      offer_request(ALL_ONES - 64'd1, 64'd3);

      // A modulus of one makes every residue zero.
      change_modulus(64'd1);
      offer_request(ALL_ONES, ALL_ONES);
      offer_request(64'd5, 64'd7);

      // A zero modulus yields a zero product.
      change_modulus(64'd0);
      offer_request(ALL_ONES, ALL_ONES);
      offer_request(64'd12345, 64'd678);

      change_modulus(64'd2);
      offer_request(64'd1, 64'd1);
      offer_request(64'd3, ALL_ONES);

      // Random part in three idling phases, with a fresh modulus per batch.
      for (int phase = 0; phase < 3; phase++) begin
         for (int batch = 0; batch < BATCHES_PER_PHASE; batch++) begin
            case ($urandom_range(0, 7))
               0: next_modulus = 64'd1;
               1: next_modulus = 64'($urandom_range(2, 255));
               2: next_modulus = 64'($urandom_range(256, 65535));
               3: next_modulus = {32'd0, $urandom};
               4: next_modulus = random_word();
               5: next_modulus = random_word() | TOP_BIT;
               6: next_modulus = ALL_ONES;
               default: next_modulus = ($urandom_range(0, 3) == 0) ? 64'd0 : MODULUS_RESET;
            endcase
            change_modulus(next_modulus);
            case (phase)
               0: begin
                  sender_idle_pct = 29;
                  receiver_idle_pct = 85;
               end
               1: begin
                  sender_idle_pct = 85;
                  receiver_idle_pct = 29;
               end
               default: begin
                  sender_idle_pct = 0;
                  receiver_idle_pct = 0;
               end
            endcase
            // Hold off the result side for a long stretch so the block backs up.
            if (phase == 2 && batch == 0) begin
               stall_requests++;
            end
            for (int n = 0; n < BATCH_ITEMS; n++) begin
               offer_request(pick_operand(current_modulus), pick_operand(current_modulus));
            end
         end
      end

      // Drain, then leave room for any stray result.
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      wait_idle();
      repeat (2 * OPERAND_WIDTH + 10) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/mm_pkg.sv
src/mm_reducer.sv
src/mm_accumulator.sv
src/modular_multiplier_unit.sv
bench/modular_multiplier_checker.sv
bench/modular_multiplier_unit_test.sv
